>>> hdl/fcba_pkg.sv
`timescale 1ns / 1ps

package fcba_pkg;

   // Store geometry: the used map is kept as rows of WORD_W bits each
   localparam int BLOCKS = 1024;
   localparam int BLK_W  = 10;
   localparam int COL_W  = 5;
   localparam int ROW_W  = BLK_W - COL_W;
   localparam int WORD_W = 1 << COL_W;
   localparam int ROWS   = BLOCKS / WORD_W;
   localparam int LINK_W = BLK_W + 1;
   localparam int CNT_W  = 11;

   // Link value that ends a chain; never a block number
   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(BLOCKS);

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_NEXT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_END     = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_AL_SCAN,
      S_AL_PICK,
      S_AL_LINK,
      S_FR_READ,
      S_FR_WRITE,
      S_NX_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic clr_step;
      logic al_scan;
      logic al_pick;
      logic al_link;
      logic fr_read;
      logic fr_write;
      logic nx_read;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic store_full;
      logic link_req;
      logic chain_end;
      logic out_free;
   } sts_type;

endpackage

>>> hdl/fcba_ctrl.sv
`timescale 1ns / 1ps

module fcba_ctrl import fcba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_op,
   input  sts_type     sts,
   output cmd_type     cmd,
   output logic        req_stall
);

   state_type state_ff;
   state_type state_in;
   op_type    op_now;

   assign op_now = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               case (op_now)
                  OP_ALLOC: state_in = S_AL_SCAN;
                  OP_FREE:  state_in = S_FR_READ;
                  OP_NEXT:  state_in = S_NX_READ;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_AL_SCAN: begin
            state_in = sts.store_full ? S_RESP : S_AL_PICK;
         end
         S_AL_PICK: begin
            state_in = sts.link_req ? S_AL_LINK : S_RESP;
         end
         S_AL_LINK:  state_in = S_RESP;
         S_FR_READ:  state_in = S_FR_WRITE;
         S_FR_WRITE: begin
            state_in = sts.chain_end ? S_RESP : S_FR_READ;
         end
         S_NX_READ:  state_in = S_RESP;
         S_RESP: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR:    cmd.clr_step = 1'b1;
         S_IDLE: begin
            req_stall     = 1'b0;
            cmd.latch_req = req_valid;
         end
         S_AL_SCAN:  cmd.al_scan  = 1'b1;
         S_AL_PICK:  cmd.al_pick  = 1'b1;
         S_AL_LINK:  cmd.al_link  = 1'b1;
         S_FR_READ:  cmd.fr_read  = 1'b1;
         S_FR_WRITE: cmd.fr_write = 1'b1;
         S_NX_READ:  cmd.nx_read  = 1'b1;
         S_RESP:     cmd.load_rsp = sts.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

>>> hdl/fcba_datapath.sv
`timescale 1ns / 1ps

module fcba_datapath import fcba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [1:0]        req_op,
   input  logic [BLK_W-1:0]  req_block,
   input  logic              req_link_after,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [BLK_W-1:0]  rsp_block_out,
   output logic [1:0]        rsp_status,
   output logic [CNT_W-1:0]  rsp_free_count
);

   // Stores
   logic [LINK_W-1:0] link_mem_ff [BLOCKS];
   logic [WORD_W-1:0] used_mem_ff [ROWS];

   // Request and walk registers
   op_type            op_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic              link_ff;
   logic [BLK_W-1:0]  cur_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [BLK_W-1:0]  found_ff;
   logic              nospace_ff;
   logic [CNT_W-1:0]  free_cnt_ff;
   logic [ROWS-1:0]   full_ff;
   logic [BLK_W-1:0]  clr_cnt_ff;
   logic [LINK_W-1:0] link_rd_ff;
   logic [WORD_W-1:0] word_rd_ff;

   // Result register
   logic              rsp_valid_ff;
   logic [BLK_W-1:0]  rsp_block_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_free_ff;
   logic [BLK_W-1:0]  rsp_block_in;
   status_type        rsp_status_in;

   logic [ROW_W-1:0]  free_row;
   logic [COL_W-1:0]  pick_col;
   logic [WORD_W-1:0] pick_word;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic              cur_used;

   logic              link_we;
   logic [BLK_W-1:0]  link_waddr;
   logic [LINK_W-1:0] link_wdata;
   logic              link_re;
   logic [BLK_W-1:0]  link_raddr;
   logic              used_we;
   logic [ROW_W-1:0]  used_waddr;
   logic [WORD_W-1:0] used_wdata;
   logic              used_re;
   logic [ROW_W-1:0]  used_raddr;

   // Lowest row that still has a free block
   always_comb begin
      free_row = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (!full_ff[i]) free_row = ROW_W'(i);
      end
   end

   // Lowest free block inside the fetched row
   always_comb begin
      pick_col = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word_rd_ff[i]) pick_col = COL_W'(i);
      end
   end

   assign pick_word = word_rd_ff | (WORD_W'(1) << pick_col);
   assign cur_row   = cur_ff[BLK_W-1:COL_W];
   assign cur_col   = cur_ff[COL_W-1:0];
   assign cur_used  = word_rd_ff[cur_col];

   // Link store port selection
   always_comb begin
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = END_MARK;
      if (cmd.clr_step) begin
         link_we    = 1'b1;
         link_waddr = clr_cnt_ff;
      end else if (cmd.al_pick) begin
         link_we    = 1'b1;
         link_waddr = {row_ff, pick_col};
      end else if (cmd.al_link) begin
         link_we    = 1'b1;
         link_waddr = blk_ff;
         link_wdata = {1'b0, found_ff};
      end else if (cmd.fr_write) begin
         link_we    = 1'b1;
      end
   end

   assign link_re    = cmd.nx_read | cmd.fr_read;
   assign link_raddr = cmd.nx_read ? blk_ff : cur_ff;

   // Used-map port selection
   always_comb begin
      used_we    = 1'b0;
      used_waddr = cur_row;
      used_wdata = word_rd_ff & ~(WORD_W'(1) << cur_col);
      if (cmd.clr_step) begin
         used_we    = 1'b1;
         used_waddr = clr_cnt_ff[ROW_W-1:0];
         used_wdata = '0;
      end else if (cmd.al_pick) begin
         used_we    = 1'b1;
         used_waddr = row_ff;
         used_wdata = pick_word;
      end else if (cmd.fr_write) begin
         used_we    = cur_used;
      end
   end

   assign used_re    = cmd.al_scan | cmd.fr_read;
   assign used_raddr = cmd.al_scan ? free_row : cur_row;

   always_ff @(posedge clock) begin
      if (link_we) link_mem_ff[link_waddr] <= link_wdata;
      if (link_re) link_rd_ff <= link_mem_ff[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem_ff[used_waddr] <= used_wdata;
      if (used_re) word_rd_ff <= used_mem_ff[used_raddr];
   end

   // Control state: clear counter, row-full flags, free count
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         full_ff     <= '0;
         free_cnt_ff <= CNT_W'(BLOCKS);
      end else begin
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.al_pick) begin
            full_ff[row_ff] <= &pick_word;
            free_cnt_ff     <= free_cnt_ff - 1'b1;
         end else if (cmd.fr_write && cur_used) begin
            full_ff[cur_row] <= 1'b0;
            free_cnt_ff      <= free_cnt_ff + 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= op_type'(req_op);
         blk_ff  <= req_block;
         link_ff <= req_link_after;
         cur_ff  <= req_block;
      end else if (cmd.fr_write) begin
         cur_ff  <= link_rd_ff[BLK_W-1:0];
      end
      if (cmd.al_scan) begin
         row_ff     <= free_row;
         nospace_ff <= &full_ff;
      end
      if (cmd.al_pick) found_ff <= {row_ff, pick_col};
   end

   // Result fields by operation
   always_comb begin
      rsp_block_in  = '0;
      rsp_status_in = ST_OK;
      case (op_ff)
         OP_ALLOC: begin
            if (nospace_ff) rsp_status_in = ST_NOSPACE;
            else            rsp_block_in  = found_ff;
         end
         OP_NEXT: begin
            if (link_rd_ff[BLK_W]) rsp_status_in = ST_END;
            else                   rsp_block_in  = link_rd_ff[BLK_W-1:0];
         end
         default: begin
            rsp_block_in  = '0;
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_block_ff  <= rsp_block_in;
         rsp_status_ff <= rsp_status_in;
         rsp_free_ff   <= free_cnt_ff;
      end
   end

   assign sts.clr_last   = (clr_cnt_ff == BLK_W'(BLOCKS - 1));
   assign sts.store_full = &full_ff;
   assign sts.link_req   = link_ff;
   assign sts.chain_end  = link_rd_ff[BLK_W];
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_out  = rsp_block_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

>>> hdl/fat_chain_block_allocator_core.sv
`timescale 1ns / 1ps
// Steps from accept to rsp_valid: allocate scans, then picks (and links when asked),
//   or goes straight to the result when the store is full; next reads one link; op 3
//   goes straight to the result; free-chain reads and then writes each block of the chain.
// Transactions: one at a time, the next accepted once the result has loaded; a load
//   waits while an earlier result sits on rsp_stall.
// Reset: synchronous; a clearing pass then ends every link and frees every block
//   while req_stall stays high.

module fat_chain_block_allocator_core import fcba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [BLK_W-1:0]  req_block,
   input  logic              req_link_after,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BLK_W-1:0]  rsp_block_out,
   output logic [1:0]        rsp_status,
   output logic [CNT_W-1:0]  rsp_free_count
);

   // The controller sequences one transaction through the datapath:
   //   allocate  - pick the lowest row that is not full (row-full flags),
   //               fetch that row of the used map, set its lowest clear bit,
   //               end the new block's link, then optionally link it after
   //               req_block.
   //   free      - walk the chain: read link and used row, then write the
   //               link back as ended and release the block if it was used.
   //               A revisited block reads an ended link, so the walk stops.
   //   next      - read one link and report it or the chain end.
   // The result register sits in the datapath, so a finished result may wait
   // on rsp_stall while the next transaction is accepted.

   cmd_type cmd;
   sts_type sts;

   fcba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   fcba_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_block      (req_block),
      .req_link_after (req_link_after),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_block_out  (rsp_block_out),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count)
   );

endmodule

>>> hdl/fcba_checker.sv
`timescale 1ns / 1ps

module fcba_checker import fcba_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_op,
   input logic [BLK_W-1:0]  req_block,
   input logic              req_link_after,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BLK_W-1:0]  rsp_block_out,
   input logic [1:0]        rsp_status,
   input logic [CNT_W-1:0]  rsp_free_count
);

   // One transaction at a time: stall right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a transaction while one was in flight");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_out)
         && $stable(rsp_status) && $stable(rsp_free_count))
      else $error("result changed while stalled");

   // Free count never exceeds the store size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_count <= CNT_W'(BLOCKS))
      else $error("free count out of range");

   // No space only when nothing is free, and then no block number
   a_nospace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOSPACE |-> rsp_free_count == '0
         && rsp_block_out == '0)
      else $error("no-space result with free blocks left");

   // Chain end carries no block number
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_END |-> rsp_block_out == '0)
      else $error("chain end with a block number");

endmodule

bind fat_chain_block_allocator_core fcba_checker u_fcba_checker (.*);

>>> verif/fcba_chain_checker.sv
`timescale 1ns / 1ps

module fcba_chain_checker import fcba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [1:0]       req_op,
   input  logic [BLK_W-1:0] req_block,
   input  logic             req_link_after,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [BLK_W-1:0] rsp_block_out,
   input  logic [1:0]       rsp_status,
   input  logic [CNT_W-1:0] rsp_free_count,
   output int               fail_count,
   output int               checked_count,
   output int               awaited_count
);

   typedef struct packed {
      logic [BLK_W-1:0] blk;
      status_type       st;
      logic [CNT_W-1:0] free_cnt;
   } alloc_result_type;

   logic              used_bits [BLOCKS];
   logic [LINK_W-1:0] succ_link [BLOCKS];
   logic [CNT_W-1:0]  free_blocks;
   alloc_result_type  awaited_results [$];
   alloc_result_type  want;

   initial begin
      fail_count    = 0;
      checked_count = 0;
      awaited_count = 0;
   end

   // Apply one request to the shadow store and return what the block must answer
   function automatic alloc_result_type serve_request(logic [1:0] op,
                                                      logic [BLK_W-1:0] blk,
                                                      logic link_it);
      alloc_result_type  r;
      int                found;
      int                cur;
      int                hops;
      int                i;
      logic [LINK_W-1:0] nxt;
      r.blk = '0;
      r.st  = ST_OK;
      case (op)
         OP_ALLOC: begin
            found = BLOCKS;
            for (i = BLOCKS - 1; i >= 0; i--)
               if (!used_bits[i]) found = i;
            if (found == BLOCKS) begin
               r.st = ST_NOSPACE;
            end else begin
               used_bits[found] = 1'b1;
               free_blocks      = free_blocks - 1'b1;
               succ_link[found] = END_MARK;
               // overwrite any old successor; a self link is legal
               if (link_it && int'(blk) < BLOCKS) succ_link[blk] = LINK_W'(found);
               r.blk = BLK_W'(found);
            end
         end
         OP_FREE: begin
            // end every visited link so that a self link cannot loop
            cur  = int'(blk);
            hops = 0;
            while (cur < BLOCKS && hops < BLOCKS) begin
               nxt = succ_link[cur];
               if (used_bits[cur]) begin
                  used_bits[cur] = 1'b0;
                  free_blocks    = free_blocks + 1'b1;
               end
               succ_link[cur] = END_MARK;
               cur  = int'(nxt);
               hops = hops + 1;
            end
         end
         OP_NEXT: begin
            if (int'(blk) < BLOCKS && int'(succ_link[blk]) < BLOCKS)
               r.blk = succ_link[blk][BLK_W-1:0];
            else
               r.st = ST_END;
         end
         default: ;
      endcase
      r.free_cnt = free_blocks;
      return r;
   endfunction

   task automatic note_mismatch(string field, int want_v, int got_v);
      fail_count = fail_count + 1;
      if (fail_count <= 10)
         $display("%0t: %s: expected %0d, got %0d", $realtime, field, want_v, got_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BLOCKS; k++) begin
            used_bits[k] = 1'b0;
            succ_link[k] = END_MARK;
         end
         free_blocks = CNT_W'(BLOCKS);
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count = checked_count + 1;
            if (awaited_results.size() == 0) begin
               note_mismatch("result with no request outstanding, block_out", -1,
                             int'(rsp_block_out));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_block_out !== want.blk)
                  note_mismatch("block_out", int'(want.blk), int'(rsp_block_out));
               if (rsp_status !== want.st)
                  note_mismatch("status", int'(want.st), int'(rsp_status));
               if (rsp_free_count !== want.free_cnt)
                  note_mismatch("free_count", int'(want.free_cnt), int'(rsp_free_count));
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(serve_request(req_op, req_block, req_link_after));
      end
      awaited_count = awaited_results.size();
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import fcba_pkg::*;

   // The store fill alone takes over a thousand transactions; keep the random phase short
   localparam int RANDOM_ITEMS = 60;
   // Slowest legal run stays far below this: ~1100 transactions, each with long
   // sender gaps and receiver stalls, a 1024-block walk, and the clearing pass.
   localparam int CYCLE_LIMIT  = 1500000;
   // Longer than any short-op latency; catch stray results after the last one
   localparam int TAIL_CYCLES  = 60;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   logic [1:0]       req_op         = OP_NONE;
   logic [BLK_W-1:0] req_block      = '0;
   logic             req_link_after = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   logic [BLK_W-1:0] rsp_block_out;
   logic [1:0]       rsp_status;
   logic [CNT_W-1:0] rsp_free_count;

   int fail_count;
   int checked_count;
   int awaited_count;

   // Sender-side bookkeeping: transactions sent and results seen drive the drain waits
   int               items_sent    = 0;
   int               rsp_count     = 0;
   logic [BLK_W-1:0] last_block    = '0;
   logic [1:0]       last_status   = ST_OK;
   int               op_tally [4]  = '{0, 0, 0, 0};
   int               nospace_seen  = 0;
   int               chains_built  = 0;
   int               longest_chain = 0;
   int               cycle_count   = 0;
   int               stall_left    = 0;
   bit               send_quiet    = 1'b0;
   bit               recv_quiet    = 1'b0;
   logic [BLK_W-1:0] chain_blocks [$];
   logic [BLK_W-1:0] kept_heads [$];

   always #6 clock = ~clock;

   fat_chain_block_allocator_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_block      (req_block),
      .req_link_after (req_link_after),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_block_out  (rsp_block_out),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count)
   );

   fcba_chain_checker u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_block      (req_block),
      .req_link_after (req_link_after),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_block_out  (rsp_block_out),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count),
      .fail_count     (fail_count),
      .checked_count  (checked_count),
      .awaited_count  (awaited_count)
   );

   // Idle length: usually short, now and then a long stretch
   function automatic int pick_delay();
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, items_sent - rsp_count);
         $display("fat_chain_block_allocator_core: mismatch");
         $finish;
      end
   end

   // Track accepted results so the sender can drain and learn allocated block numbers
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count   <= rsp_count + 1;
         last_block  <= rsp_block_out;
         last_status <= rsp_status;
         if (rsp_status == ST_NOSPACE) nospace_seen <= nospace_seen + 1;
      end
   end

   // Receiver: stall in random bursts, drop into quiet stretches now and then
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 149) == 0) recv_quiet <= ~recv_quiet;
         if (!recv_quiet && $urandom_range(0, 99) < 30) stall_left <= pick_delay();
      end
   end

   // Present one transaction at a falling edge and hold it until a rising edge takes it.
   // Valid stays high between back-to-back transactions.
   task automatic send_req(logic [1:0] op, logic [BLK_W-1:0] blk, logic link_it);
      int gap;
      gap = 0;
      if (!send_quiet && $urandom_range(0, 99) >= 50) gap = pick_delay();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_block      <= blk;
      req_link_after <= link_it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent   = items_sent + 1;
      op_tally[op] = op_tally[op] + 1;
   endtask

   // Drop valid and hold off until every outstanding result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_count != items_sent) @(posedge clock);
   endtask

   // Build a chain one allocation at a time, walk it with next, then free it
   // (from the head, from the middle, or keep it around for a later free)
   task automatic run_chain();
      int               len;
      int               k;
      int               pick;
      bit               full;
      logic [BLK_W-1:0] tgt;
      logic             link_it;
      len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      full = 1'b0;
      chain_blocks.delete();
      for (k = 0; k < len && !full; k++) begin
         if (k == 0) begin
            tgt     = $urandom_range(0, BLOCKS - 1);
            link_it = ($urandom_range(0, 3) == 0);
         end else if ($urandom_range(0, 14) == 0) begin
            // break the chain now and then: link somewhere else or not at all
            tgt     = $urandom_range(0, BLOCKS - 1);
            link_it = $urandom_range(0, 1);
         end else begin
            tgt     = chain_blocks[$];
            link_it = 1'b1;
         end
         send_req(OP_ALLOC, tgt, link_it);
         drain_results();
         if (last_status != ST_OK) full = 1'b1;
         else chain_blocks.push_back(last_block);
      end
      if (chain_blocks.size() == 0) return;
      chains_built = chains_built + 1;
      if (chain_blocks.size() > longest_chain) longest_chain = chain_blocks.size();
      // Walk part of the chain back-to-back, then one stray query
      for (k = 0; k < chain_blocks.size(); k++)
         if ($urandom_range(0, 1)) send_req(OP_NEXT, chain_blocks[k], $urandom_range(0, 1));
      send_req(OP_NEXT, $urandom_range(0, BLOCKS - 1), 1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 65)
         send_req(OP_FREE, chain_blocks[0], $urandom_range(0, 1));
      else if (pick < 80)
         send_req(OP_FREE, chain_blocks[$urandom_range(0, chain_blocks.size() - 1)], 1'b0);
      else
         kept_heads.push_back(chain_blocks[0]);
   endtask

   // Random requests of every kind, block numbers biased toward the ends of the range
   task automatic run_noise();
      int               n;
      int               k;
      int               pick;
      logic [BLK_W-1:0] blk;
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0) blk = '0;
         else if (pick == 1) blk = BLK_W'(BLOCKS - 1);
         else blk = $urandom_range(0, BLOCKS - 1);
         send_req($urandom_range(0, 3), blk, $urandom_range(0, 1));
      end
   endtask

   initial begin
      int k;
      int pick;
      int random_start;

      // Release reset at a falling edge; the block then clears its store with req_stall high
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: store starts empty, so allocations come out in order from block 0
      send_req(OP_NONE,  10'd1023, 1'b1);   // unused op
      send_req(OP_NEXT,  10'd1023, 1'b0);   // next at chain end
      send_req(OP_ALLOC, 10'd0,    1'b1);   // block 0 linked after itself
      send_req(OP_NEXT,  10'd0,    1'b0);   // self link reads back
      send_req(OP_FREE,  10'd0,    1'b0);   // walk over the self link must end
      send_req(OP_FREE,  10'd0,    1'b1);   // free a block that is already free
      send_req(OP_ALLOC, 10'd0,    1'b0);   // block 0, no link
      send_req(OP_ALLOC, 10'd0,    1'b1);   // block 1 after 0
      send_req(OP_ALLOC, 10'd1,    1'b1);   // block 2 after 1
      send_req(OP_ALLOC, 10'd0,    1'b1);   // block 3 replaces 0's successor
      send_req(OP_NEXT,  10'd0,    1'b0);
      send_req(OP_NEXT,  10'd1,    1'b0);
      send_req(OP_NEXT,  10'd3,    1'b1);
      send_req(OP_ALLOC, 10'd1023, 1'b1);   // link from a free block
      send_req(OP_NEXT,  10'd1023, 1'b0);
      send_req(OP_FREE,  10'd1023, 1'b0);   // start on a free block, still walks to 4
      send_req(OP_FREE,  10'd0,    1'b0);
      send_req(OP_FREE,  10'd1,    1'b0);
      send_req(OP_NONE,  10'd0,    1'b0);
      send_req(OP_NEXT,  10'd512,  1'b0);

      // Pause until the block has answered everything before the fill
      drain_results();

      // Fill the whole store as one chain 0 -> 1 -> ... -> 1023, then hit the full case
      send_req(OP_ALLOC, 10'd0, 1'b0);
      for (k = 1; k < BLOCKS; k++) send_req(OP_ALLOC, BLK_W'(k - 1), 1'b1);
      send_req(OP_ALLOC, 10'd5,    1'b1);
      send_req(OP_ALLOC, 10'd1023, 1'b0);
      send_req(OP_NEXT,  10'd511,  1'b0);
      send_req(OP_NEXT,  10'd1023, 1'b0);
      send_req(OP_FREE,  10'd0,    1'b0);   // longest possible walk
      send_req(OP_NEXT,  10'd0,    1'b0);
      drain_results();

      // Random phase: mostly well-formed chain lifecycles, some noise and late frees
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         send_quiet = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            run_chain();
         end else if (pick < 72 && kept_heads.size() > 0) begin
            send_req(OP_FREE, kept_heads.pop_front(), $urandom_range(0, 1));
         end else begin
            run_noise();
            if ($urandom_range(0, 9) == 0) drain_results();
         end
      end

      // Wait out every result, then a quiet tail to catch extras
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d allocate, %0d free-chain, %0d next, %0d unused op); %0d results checked.",
               items_sent, op_tally[OP_ALLOC], op_tally[OP_FREE], op_tally[OP_NEXT],
               op_tally[OP_NONE], checked_count);
      $display("Built %0d chains (longest %0d), filled the store once, %0d no-space answers.",
               chains_built, longest_chain, nospace_seen);
      if (fail_count == 0 && awaited_count == 0)
         $display("fat_chain_block_allocator_core: match");
      else
         $display("fat_chain_block_allocator_core: mismatch");
      $finish;
   end

endmodule

>>> sim.f
hdl/fcba_pkg.sv
hdl/fcba_ctrl.sv
hdl/fcba_datapath.sv
hdl/fat_chain_block_allocator_core.sv
hdl/fcba_checker.sv
verif/fcba_chain_checker.sv
verif/tb.sv
